// ----- rtl/dll_pkg.sv -----
`default_nettype none
package dll_pkg;

  localparam int unsigned DEF_POOL_NODES = 256;
  localparam int unsigned DEF_VALUE_BITS = 32;
  localparam int unsigned CMD_BITS       = 5;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_CLEAR      = 5'd0,
    CMD_INS_FIRST  = 5'd1,
    CMD_INS_LAST   = 5'd2,
    CMD_FIRST      = 5'd3,
    CMD_LAST       = 5'd4,
    CMD_GET_FIRST  = 5'd5,
    CMD_GET_LAST   = 5'd6,
    CMD_DEL_FIRST  = 5'd7,
    CMD_DEL_LAST   = 5'd8,
    CMD_DEL_AFTER  = 5'd9,
    CMD_DEL_BEFORE = 5'd10,
    CMD_INS_AFTER  = 5'd11,
    CMD_INS_BEFORE = 5'd12,
    CMD_GET        = 5'd13,
    CMD_SET        = 5'd14,
    CMD_NEXT       = 5'd15,
    CMD_PREV       = 5'd16,
    CMD_IS_ACTIVE  = 5'd17
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD1,
    ST_RD2,
    ST_WR1,
    ST_WR2,
    ST_RESP
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/dll_if.sv -----
`default_nettype none
interface dll_req_if #(
  parameter int unsigned VALUE_BITS = dll_pkg::DEF_VALUE_BITS
);
  logic                         valid;
  logic                         ready;
  logic [dll_pkg::CMD_BITS-1:0] command;
  logic signed [VALUE_BITS-1:0] value;
  modport source (output valid, command, value, input ready);
  modport sink   (input valid, command, value, output ready);
endinterface

interface dll_rsp_if #(
  parameter int unsigned VALUE_BITS = dll_pkg::DEF_VALUE_BITS
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] read_value;
  logic                         error;
  logic                         active;
  modport source (output valid, read_value, error, active, input ready);
  modport sink   (input valid, read_value, error, active, output ready);
endinterface
`default_nettype wire

// ----- rtl/doubly_linked_list_with_cursor.sv -----
`default_nettype none
// Channel | Dir | Payload                          | Handshake
// req     | in  | command, value                   | valid/ready
// rsp     | out | read_value, error, active        | valid/ready
//
// The result is offered once an accepted word has passed the read states RD1
// and RD2 on the node memories (registered read ports; some commands chase a
// link read in RD1) and then the write states WR1 and WR2, since each of the
// three node memories has a single write port. Input is ready again the cycle
// after the result is taken.
// Reset clears head, tail, cursor, free list and the allocator; the node
// memories are not cleared, only written entries are ever used.
// One word is in flight at a time; a stalled result holds until taken.
module doubly_linked_list_with_cursor #(
  parameter int unsigned POOL_NODES = dll_pkg::DEF_POOL_NODES,
  parameter int unsigned VALUE_BITS = dll_pkg::DEF_VALUE_BITS
) (
  input  wire logic clk,
  input  wire logic rst,
  dll_req_if.sink   req,
  dll_rsp_if.source rsp
);
  import dll_pkg::*;

  // Indexes carry one extra code, POOL_NODES, which stands for null.
  localparam int unsigned IW = $clog2(POOL_NODES + 1);
  localparam int unsigned AW = $clog2(POOL_NODES);
  localparam logic [IW-1:0] NIL = IW'(POOL_NODES);

  // Node memories, each with one write port and a registered read port.
  logic [VALUE_BITS-1:0] mem_val  [POOL_NODES];
  logic [IW-1:0]         mem_next [POOL_NODES];
  logic [IW-1:0]         mem_prev [POOL_NODES];
  logic [VALUE_BITS-1:0] q_val;
  logic [IW-1:0]         q_next, q_prev;

  logic [IW-1:0]         ra;
  logic                  v_we, n_we, p_we;
  logic [IW-1:0]         v_wa, n_wa, p_wa;
  logic [VALUE_BITS-1:0] v_wd;
  logic [IW-1:0]         n_wd, p_wd;

  state_t state, state_next;

  logic [CMD_BITS-1:0]   cmd;
  logic [VALUE_BITS-1:0] val;
  logic [IW-1:0]         head, tail, cur, free_head, fresh;
  logic [IW-1:0]         r1_next, r1_prev;
  logic [VALUE_BITS-1:0] r1_val;
  logic [IW-1:0]         n, m;
  logic                  ok_r, lnk;
  logic [VALUE_BITS-1:0] rd;
  logic                  err;

  always_ff @(posedge clk) begin
    if (v_we) mem_val[v_wa[AW-1:0]] <= v_wd;
    if (n_we) mem_next[n_wa[AW-1:0]] <= n_wd;
    if (p_we) mem_prev[p_wa[AW-1:0]] <= p_wd;
    q_val  <= mem_val[ra[AW-1:0]];
    q_next <= mem_next[ra[AW-1:0]];
    q_prev <= mem_prev[ra[AW-1:0]];
  end

  // Allocation: free list first, then never-used nodes.
  logic          have_free, have_fresh, full;
  logic [IW-1:0] alloc_n, fl_next;
  assign have_free  = free_head < NIL;
  assign have_fresh = fresh < NIL;
  assign full       = !have_free && !have_fresh;
  assign alloc_n    = have_free ? free_head : fresh;
  assign fl_next    = (cmd == CMD_INS_FIRST || cmd == CMD_INS_LAST) ? r1_next : q_next;

  // Decisions taken in the first write cycle.
  logic cur_ok, head_ok, tail_ok, ia_tail, ib_head, da_ok, db_ok;
  assign cur_ok  = cur < NIL;
  assign head_ok = head < NIL;
  assign tail_ok = tail < NIL;
  assign ia_tail = (cur == tail) || !(r1_next < NIL);
  assign ib_head = (cur == head) || !(r1_prev < NIL);
  assign da_ok   = cur_ok && (r1_next < NIL);
  assign db_ok   = cur_ok && (r1_prev < NIL);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (req.valid) state_next = ST_RD1;
      ST_RD1:  state_next = ST_RD2;
      ST_RD2:  state_next = ST_WR1;
      ST_WR1:  state_next = ST_WR2;
      ST_WR2:  state_next = ST_RESP;
      ST_RESP: if (rsp.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  assign req.ready      = (state == ST_IDLE);
  assign rsp.valid      = (state == ST_RESP);
  assign rsp.read_value = rd;
  assign rsp.error      = err;
  assign rsp.active     = cur_ok;

  // Read address: first read at head, tail, cursor or free head; the
  // second read follows a link or fetches the free list successor.
  always_comb begin
    ra = cur;
    if (state == ST_RD1) begin
      case (cmd)
        CMD_GET_FIRST, CMD_DEL_FIRST: ra = head;
        CMD_GET_LAST, CMD_DEL_LAST:   ra = tail;
        CMD_INS_FIRST, CMD_INS_LAST:  ra = free_head;
        default:                      ra = cur;
      endcase
    end else if (state == ST_RD2) begin
      case (cmd)
        CMD_DEL_AFTER:  ra = q_next;
        CMD_DEL_BEFORE: ra = q_prev;
        default:        ra = free_head;
      endcase
    end
  end

  // Write ports.
  always_comb begin
    v_we = 1'b0; v_wa = n; v_wd = val;
    n_we = 1'b0; n_wa = n; n_wd = NIL;
    p_we = 1'b0; p_wa = n; p_wd = NIL;
    if (state == ST_WR1) begin
      case (cmd)
        CMD_INS_FIRST: if (!full) begin
          v_we = 1'b1; v_wa = alloc_n;
          n_we = 1'b1; n_wa = alloc_n; n_wd = head;
          p_we = 1'b1; p_wa = alloc_n; p_wd = NIL;
        end
        CMD_INS_LAST: if (!full) begin
          v_we = 1'b1; v_wa = alloc_n;
          n_we = 1'b1; n_wa = alloc_n; n_wd = NIL;
          p_we = 1'b1; p_wa = alloc_n; p_wd = tail;
        end
        CMD_INS_AFTER: if (cur_ok && !full) begin
          v_we = 1'b1; v_wa = alloc_n;
          n_we = 1'b1; n_wa = alloc_n; n_wd = r1_next;
          p_we = 1'b1; p_wa = alloc_n; p_wd = cur;
        end
        CMD_INS_BEFORE: if (cur_ok && !full) begin
          v_we = 1'b1; v_wa = alloc_n;
          n_we = 1'b1; n_wa = alloc_n; n_wd = cur;
          p_we = 1'b1; p_wa = alloc_n; p_wd = r1_prev;
        end
        CMD_DEL_FIRST: if (head_ok && head != tail && r1_next < NIL) begin
          p_we = 1'b1; p_wa = r1_next; p_wd = NIL;
        end
        CMD_DEL_LAST: if (tail_ok && tail != head && r1_prev < NIL) begin
          n_we = 1'b1; n_wa = r1_prev; n_wd = NIL;
        end
        CMD_DEL_AFTER: if (da_ok) begin
          n_we = 1'b1; n_wa = cur; n_wd = q_next;
          if (!(r1_next == tail || !(q_next < NIL))) begin
            p_we = 1'b1; p_wa = q_next; p_wd = cur;
          end
        end
        CMD_DEL_BEFORE: if (db_ok) begin
          p_we = 1'b1; p_wa = cur; p_wd = q_prev;
          if (!(r1_prev == head || !(q_prev < NIL))) begin
            n_we = 1'b1; n_wa = q_prev; n_wd = cur;
          end
        end
        CMD_SET: if (cur_ok) begin
          v_we = 1'b1; v_wa = cur;
        end
        default: ;
      endcase
    end else if (state == ST_WR2 && ok_r) begin
      case (cmd)
        CMD_INS_FIRST: if (lnk) begin
          p_we = 1'b1; p_wa = m; p_wd = n;
        end
        CMD_INS_LAST: if (lnk) begin
          n_we = 1'b1; n_wa = m; n_wd = n;
        end
        CMD_INS_AFTER: begin
          n_we = 1'b1; n_wa = cur; n_wd = n;
          if (lnk) begin
            p_we = 1'b1; p_wa = m; p_wd = n;
          end
        end
        CMD_INS_BEFORE: begin
          p_we = 1'b1; p_wa = cur; p_wd = n;
          if (lnk) begin
            n_we = 1'b1; n_wa = m; n_wd = n;
          end
        end
        CMD_DEL_FIRST, CMD_DEL_LAST, CMD_DEL_AFTER, CMD_DEL_BEFORE: begin
          n_we = 1'b1; n_wa = n; n_wd = free_head;
        end
        default: ;
      endcase
    end
  end

  // Pointer registers and result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= NIL;
      tail      <= NIL;
      cur       <= NIL;
      free_head <= NIL;
      fresh     <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: if (req.valid) begin
          cmd  <= req.command;
          val  <= req.value;
          rd   <= '0;
          err  <= 1'b0;
          ok_r <= 1'b0;
          lnk  <= 1'b0;
        end
        ST_RD2: begin
          r1_next <= q_next;
          r1_prev <= q_prev;
          r1_val  <= q_val;
        end
        ST_WR1: begin
          case (cmd)
            CMD_CLEAR: begin
              head <= NIL; tail <= NIL; cur <= NIL;
              free_head <= NIL; fresh <= '0;
            end
            CMD_INS_FIRST, CMD_INS_LAST: begin
              if (full) err <= 1'b1;
              else begin
                ok_r <= 1'b1;
                n    <= alloc_n;
                if (have_free) free_head <= fl_next;
                else fresh <= fresh + 1'b1;
                if (cmd == CMD_INS_FIRST) begin
                  m <= head; lnk <= head_ok; head <= alloc_n;
                  if (!head_ok) tail <= alloc_n;
                end else begin
                  m <= tail; lnk <= tail_ok; tail <= alloc_n;
                  if (!tail_ok) head <= alloc_n;
                end
              end
            end
            CMD_INS_AFTER, CMD_INS_BEFORE: if (cur_ok) begin
              if (full) err <= 1'b1;
              else begin
                ok_r <= 1'b1;
                n    <= alloc_n;
                if (have_free) free_head <= fl_next;
                else fresh <= fresh + 1'b1;
                if (cmd == CMD_INS_AFTER) begin
                  m <= r1_next; lnk <= !ia_tail;
                  if (ia_tail) tail <= alloc_n;
                end else begin
                  m <= r1_prev; lnk <= !ib_head;
                  if (ib_head) head <= alloc_n;
                end
              end
            end
            CMD_FIRST: cur <= head;
            CMD_LAST:  cur <= tail;
            CMD_GET_FIRST: if (head_ok) rd <= r1_val; else err <= 1'b1;
            CMD_GET_LAST:  if (tail_ok) rd <= r1_val; else err <= 1'b1;
            CMD_GET:       if (cur_ok) rd <= r1_val; else err <= 1'b1;
            CMD_DEL_FIRST: if (head_ok) begin
              ok_r <= 1'b1; n <= head;
              if (cur == head) cur <= NIL;
              if (head == tail) begin
                head <= NIL; tail <= NIL;
              end else head <= r1_next;
            end
            CMD_DEL_LAST: if (tail_ok) begin
              ok_r <= 1'b1; n <= tail;
              if (cur == tail) cur <= NIL;
              if (head == tail) begin
                head <= NIL; tail <= NIL;
              end else tail <= r1_prev;
            end
            CMD_DEL_AFTER: if (da_ok) begin
              ok_r <= 1'b1; n <= r1_next;
              if (r1_next == tail || !(q_next < NIL)) tail <= cur;
            end
            CMD_DEL_BEFORE: if (db_ok) begin
              ok_r <= 1'b1; n <= r1_prev;
              if (r1_prev == head || !(q_prev < NIL)) head <= cur;
            end
            CMD_NEXT: if (cur_ok) cur <= (r1_next < NIL) ? r1_next : NIL;
            CMD_PREV: if (cur_ok) cur <= (r1_prev < NIL) ? r1_prev : NIL;
            default: ;
          endcase
        end
        ST_WR2: begin
          // A released node goes on top of the free list.
          if (ok_r && (cmd == CMD_DEL_FIRST || cmd == CMD_DEL_LAST ||
                       cmd == CMD_DEL_AFTER || cmd == CMD_DEL_BEFORE))
            free_head <= n;
        end
        default: ;
      endcase
    end
  end

  a_ends_agree: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESP) |-> ((head == NIL) == (tail == NIL)))
    else $error("head and tail disagree on empty list");

  a_fresh_range: assert property (@(posedge clk) disable iff (rst)
    fresh <= NIL)
    else $error("allocator count past pool size");

  a_accept_seq: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state == ST_RD1))
    else $error("accepted word did not start a read");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WR1 && cmd == CMD_CLEAR) |=> (head == NIL && cur == NIL && fresh == '0))
    else $error("clear left pointers set");

endmodule
`default_nettype wire
